### design/mios_pkg.sv
package mios_pkg;

    // Field widths fixed by the channel formats
    localparam int CHANNEL_BITS      = 4;
    localparam int INPUT_SAMPLE_BITS = 12;
    localparam int RESULT_BITS       = 16;
    localparam int GAIN_BITS         = 15;
    localparam int SCALE_BITS        = 18;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 18;

    // Q0.15 gains, Q16 scale factor
    localparam int FILTER_SHIFT    = 15;
    localparam int SCALE_FRAC_BITS = 16;

    localparam logic [GAIN_BITS-1:0]  NEW_GAIN_RESET = 15'd6554;
    localparam logic [GAIN_BITS-1:0]  OLD_GAIN_RESET = 15'd26214;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET    = 18'd68950;

    localparam logic [RESULT_BITS-1:0] RESULT_POS_MAX = 16'h7FFF;
    localparam logic [RESULT_BITS-1:0] RESULT_NEG_MAX = 16'h8000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_NEW_GAIN = 2'd0,
        CFG_OLD_GAIN = 2'd1,
        CFG_SCALE    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FILTER,
        ST_DIFF,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                         mode;
        logic [CHANNEL_BITS-1:0]      channel;
        logic [INPUT_SAMPLE_BITS-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]       out_channel;
        logic signed [RESULT_BITS-1:0] pressure_centi_kpa;
        logic                          offset_captured;
    } out_t;

endpackage

### design/mios_ram.sv
module mios_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/multichannel_iir_offset_scaler_core.sv
// Multichannel pressure conditioner: per-channel IIR low-pass with offsets.
// Input channel (s_valid/s_ready/s_data): one word per ADC sample, carrying
// mode, channel and sample. Mode 0 filters the sample into the channel's
// level and converts the level, less the channel's offset, to 0.01 kPa.
// Mode 1 stores the sample as the channel's offset and returns an
// acknowledge word with pressure 0 and offset_captured set.
// Result channel (m_valid/m_ready/m_data): exactly one word per input word,
// in order, held in an output register until taken.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; index 0 new-sample gain, 1 old-level gain, 2 pressure scale;
// other indices are dropped. Write only while the block is idle.
// Steps: a sample word goes through the read, filter (level write-back),
// offset, scale and final steps (ST_READ to ST_DONE), one register stage
// each; a capture word goes straight to the final step. One word at a time:
// s_ready is high again from the edge that loads the output register, so
// no new word is taken before the last one has reached that register.
// If the receiver stalls, the next word is still accepted and worked on,
// then waits in its final step until the output register is free.
// Reset clears the per-entry valid bits, so levels and offsets read as zero
// until written, and restores the default gains and scale.
module multichannel_iir_offset_scaler_core #(
    parameter int CHANNELS      = 16,
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mios_pkg::in_t                         s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mios_pkg::out_t                        m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mios_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mios_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_CODES = 2 ** mios_pkg::CHANNEL_BITS;
    localparam int LB       = SAMPLE_BITS + FRACTION_BITS;        // level width
    localparam int PRODW    = mios_pkg::GAIN_BITS + LB;           // filter product
    localparam int ACCW     = PRODW + 1;                          // filter sum
    localparam int SS       = FRACTION_BITS + mios_pkg::SCALE_FRAC_BITS;
    localparam int PW       = LB + mios_pkg::SCALE_BITS;          // scale product
    localparam int RW       = PW + 1 - SS;                        // rounded result
    localparam int CW       = (RW > 17) ? RW : 17;                // compare width

    localparam logic [ACCW-1:0] ACC_HALF  = ACCW'(1) << (mios_pkg::FILTER_SHIFT - 1);
    localparam logic [PW:0]     P_HALF    = (PW + 1)'(1) << (SS - 1);
    localparam logic [LB-1:0]   LEVEL_MAX = '1;

    // Control
    mios_pkg::state_t state_reg, state_next;
    logic             load_out;
    logic             lvl_we;
    logic             off_we;
    logic             accept;

    // Configuration
    logic [mios_pkg::GAIN_BITS-1:0]  gain_new_reg;
    logic [mios_pkg::GAIN_BITS-1:0]  gain_old_reg;
    logic [mios_pkg::SCALE_BITS-1:0] scale_reg;

    // Per-entry valid bits: an entry not yet written reads as zero
    logic [CHANNELS-1:0] lvl_valid_reg;
    logic [CHANNELS-1:0] off_valid_reg;

    // Channel to memory entry, channel modulo CHANNELS
    logic [IDX_W-1:0] ch_map [CH_CODES];

    // Item and datapath
    mios_pkg::in_t            item_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         s_idx;
    logic [SAMPLE_BITS-1:0]   s_x;
    logic [SAMPLE_BITS-1:0]   item_x;
    logic [LB-1:0]            lvl_rdata;
    logic [SAMPLE_BITS-1:0]   off_rdata;
    logic [LB-1:0]            lvl_cur;
    logic [SAMPLE_BITS-1:0]   off_cur;
    logic [PRODW-1:0]         prod_n_reg, prod_n_next;
    logic [PRODW-1:0]         prod_o_reg, prod_o_next;
    logic [LB-1:0]            off_reg, off_next;
    logic [ACCW-1:0]          acc_round;
    logic [LB:0]              y_wide;
    logic [LB-1:0]            y_reg, y_next;
    logic                     neg_reg, neg_next;
    logic [LB-1:0]            mag_reg, mag_next;
    logic [PW-1:0]            p_reg, p_next;
    logic [PW:0]              p_round;
    logic [CW-1:0]            r_cmp;
    logic [mios_pkg::RESULT_BITS-1:0] pres_mag;
    mios_pkg::out_t           out_reg, out_next;
    logic                     m_valid_reg;

    for (genvar g = 0; g < CH_CODES; g++) begin : g_ch_map
        assign ch_map[g] = IDX_W'(g % CHANNELS);
    end

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign s_idx     = ch_map[s_data.channel];
    assign s_x       = SAMPLE_BITS'(s_data.sample);
    assign item_x    = SAMPLE_BITS'(item_reg.sample);

    // ---------------------------------------------------------------
    // State memories: filtered level and captured offset
    // ---------------------------------------------------------------
    mios_ram #(
        .WIDTH (LB),
        .DEPTH (CHANNELS)
    ) u_level_ram (
        .clk   (aclk),
        .we    (lvl_we),
        .waddr (idx_reg),
        .wdata (y_next),
        .raddr (s_idx),
        .rdata (lvl_rdata)
    );

    mios_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CHANNELS)
    ) u_offset_ram (
        .clk   (aclk),
        .we    (off_we),
        .waddr (s_idx),
        .wdata (s_x),
        .raddr (s_idx),
        .rdata (off_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mios_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = s_data.mode ? mios_pkg::ST_DONE : mios_pkg::ST_READ;
                end
            end
            mios_pkg::ST_READ:   state_next = mios_pkg::ST_FILTER;
            mios_pkg::ST_FILTER: state_next = mios_pkg::ST_DIFF;
            mios_pkg::ST_DIFF:   state_next = mios_pkg::ST_SCALE;
            mios_pkg::ST_SCALE:  state_next = mios_pkg::ST_DONE;
            mios_pkg::ST_DONE: begin
                if (load_out) begin
                    state_next = mios_pkg::ST_IDLE;
                end
            end
            default:             state_next = mios_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        lvl_we   = 1'b0;
        off_we   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            mios_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                off_we  = s_valid && s_data.mode;
            end
            mios_pkg::ST_FILTER: lvl_we = 1'b1;
            mios_pkg::ST_DONE:   load_out = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mios_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Configuration writes; unknown indices are dropped
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_new_reg <= mios_pkg::NEW_GAIN_RESET;
            gain_old_reg <= mios_pkg::OLD_GAIN_RESET;
            scale_reg    <= mios_pkg::SCALE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                mios_pkg::CFG_NEW_GAIN: gain_new_reg <= cfg_data[mios_pkg::GAIN_BITS-1:0];
                mios_pkg::CFG_OLD_GAIN: gain_old_reg <= cfg_data[mios_pkg::GAIN_BITS-1:0];
                mios_pkg::CFG_SCALE:    scale_reg    <= cfg_data;
                default: begin
                    gain_new_reg <= gain_new_reg;
                end
            endcase
        end
    end

    // Mark entries as written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_valid_reg <= '0;
            off_valid_reg <= '0;
        end else begin
            if (lvl_we) begin
                lvl_valid_reg[idx_reg] <= 1'b1;
            end
            if (off_we) begin
                off_valid_reg[s_idx] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    // Read step: take the memory words, form both filter products
    assign lvl_cur     = lvl_valid_reg[idx_reg] ? lvl_rdata : '0;
    assign off_cur     = off_valid_reg[idx_reg] ? off_rdata : '0;
    assign prod_n_next = PRODW'(gain_new_reg) * (PRODW'(item_x) << FRACTION_BITS);
    assign prod_o_next = PRODW'(gain_old_reg) * PRODW'(lvl_cur);
    assign off_next    = LB'(off_cur) << FRACTION_BITS;

    // Filter step: round half up, saturate, write back
    assign acc_round = ACCW'(prod_n_reg) + ACCW'(prod_o_reg) + ACC_HALF;
    assign y_wide    = acc_round[ACCW-1:mios_pkg::FILTER_SHIFT];
    assign y_next    = y_wide[LB] ? LEVEL_MAX : y_wide[LB-1:0];

    // Offset step: sign and magnitude of level less offset
    assign neg_next = y_reg < off_reg;
    assign mag_next = neg_next ? (off_reg - y_reg) : (y_reg - off_reg);

    // Scale step
    assign p_next = PW'(mag_reg) * PW'(scale_reg);

    // Final step: round half away from zero, saturate, restore sign
    assign p_round = {1'b0, p_reg} + P_HALF;
    assign r_cmp   = CW'(p_round[PW:SS]);

    always_comb begin
        if (neg_reg) begin
            pres_mag = (r_cmp > CW'(mios_pkg::RESULT_NEG_MAX)) ?
                       mios_pkg::RESULT_NEG_MAX : r_cmp[mios_pkg::RESULT_BITS-1:0];
        end else begin
            pres_mag = (r_cmp > CW'(mios_pkg::RESULT_POS_MAX)) ?
                       mios_pkg::RESULT_POS_MAX : r_cmp[mios_pkg::RESULT_BITS-1:0];
        end
        out_next.out_channel = item_reg.channel;
        if (item_reg.mode) begin
            out_next.pressure_centi_kpa = '0;
            out_next.offset_captured    = 1'b1;
        end else begin
            out_next.pressure_centi_kpa = neg_reg ? (16'd0 - pres_mag) : pres_mag;
            out_next.offset_captured    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
            idx_reg  <= s_idx;
        end
        if (state_reg == mios_pkg::ST_READ) begin
            prod_n_reg <= prod_n_next;
            prod_o_reg <= prod_o_next;
            off_reg    <= off_next;
        end
        if (state_reg == mios_pkg::ST_FILTER) begin
            y_reg <= y_next;
        end
        if (state_reg == mios_pkg::ST_DIFF) begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
        if (state_reg == mios_pkg::ST_SCALE) begin
            p_reg <= p_next;
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### design/mios_checker.sv
module mios_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input mios_pkg::out_t                      m_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Drop any result after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One word in flight: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word in progress");

    // Acknowledge words carry zero pressure
    a_capture_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_data.offset_captured || m_data.pressure_centi_kpa == 16'sd0)
        else $error("capture acknowledge with non-zero pressure");

endmodule

bind multichannel_iir_offset_scaler_core mios_checker u_mios_checker (.*);
